// ===== rtl/nand_flash_command_sequencer_unit_assert.svh =====
// assertion macros for the nand command sequencer
// clocked on clk_i, disabled while rst_ni is low; no other dependencies
`ifndef NAND_FLASH_COMMAND_SEQUENCER_UNIT_ASSERT_SVH
`define NAND_FLASH_COMMAND_SEQUENCER_UNIT_ASSERT_SVH

// condition in the same cycle
`define NFCS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition in the next cycle
`define NFCS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/nfcs_pkg.sv =====
// shared types and codes of the nand command sequencer
// used by the front, queue, back and top modules; no dependencies
package nfcs_pkg;

  localparam int unsigned PagesPerBlock = 32;
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned QueuePtrW     = $clog2(QueueDepth);
  localparam int unsigned QueueCntW     = $clog2(QueueDepth + 1);

  // request codes
  localparam logic [2:0] OpReadId     = 3'd0;
  localparam logic [2:0] OpProgStart  = 3'd1;
  localparam logic [2:0] OpWriteByte  = 3'd2;
  localparam logic [2:0] OpProgCommit = 3'd3;
  localparam logic [2:0] OpReadStart  = 3'd4;
  localparam logic [2:0] OpRetByte    = 3'd5;
  localparam logic [2:0] OpErase      = 3'd6;
  localparam logic [2:0] OpFinish     = 3'd7;

  // bus cycle kinds
  localparam logic [2:0] KindCmd   = 3'd0;
  localparam logic [2:0] KindAddr  = 3'd1;
  localparam logic [2:0] KindWrite = 3'd2;
  localparam logic [2:0] KindRead  = 3'd3;
  localparam logic [2:0] KindWait  = 3'd4;
  localparam logic [2:0] KindDesel = 3'd5;

  // chip command bytes
  localparam logic [7:0] CmdPtrA        = 8'h00;
  localparam logic [7:0] CmdPtrB        = 8'h01;
  localparam logic [7:0] CmdReadId      = 8'h90;
  localparam logic [7:0] CmdProgSetup   = 8'h80;
  localparam logic [7:0] CmdProgConfirm = 8'h10;
  localparam logic [7:0] CmdStatus      = 8'h70;
  localparam logic [7:0] CmdEraseSetup  = 8'h60;
  localparam logic [7:0] CmdEraseConfirm = 8'hD0;
  localparam logic [7:0] IdAddr         = 8'h00;

  // sequence codes carried from front to back
  localparam logic [3:0] SeqReadId  = 4'd0;
  localparam logic [3:0] SeqProg    = 4'd1;
  localparam logic [3:0] SeqWrite   = 4'd2;
  localparam logic [3:0] SeqCommit  = 4'd3;
  localparam logic [3:0] SeqRdStart = 4'd4;
  localparam logic [3:0] SeqRdByte  = 4'd5;
  localparam logic [3:0] SeqIdDone  = 4'd6;
  localparam logic [3:0] SeqStatus  = 4'd7;
  localparam logic [3:0] SeqErase   = 4'd8;
  localparam logic [3:0] SeqDesel   = 4'd9;

  typedef struct packed {
    logic [3:0]  seq;
    logic        ptr;
    logic [7:0]  col;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [15:0] id;
  } job_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  bus_byte;
    logic [15:0] id_value;
    logic        id_valid;
    logic        status_valid;
    logic        status_fail;
    logic        last;
  } result_t;

endpackage

// ===== rtl/nfcs_front.sv =====
// request front end: tracks the phase, classifies requests into jobs
// depends on nfcs_pkg
module nfcs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [2:0]     op_i,
  input  logic [8:0]     column_i,
  input  logic [15:0]    page_i,
  input  logic [10:0]    block_i,
  input  logic [7:0]     write_data_i,
  input  logic [7:0]     flash_byte_i,
  input  logic           full_i,
  output logic           push_o,
  output nfcs_pkg::job_t job_o
);
  import nfcs_pkg::*;

  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhId1   = 3'd1;
  localparam logic [2:0] PhId2   = 3'd2;
  localparam logic [2:0] PhProg  = 3'd3;
  localparam logic [2:0] PhPstat = 3'd4;
  localparam logic [2:0] PhRead  = 3'd5;
  localparam logic [2:0] PhEstat = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  id_hi_q, id_hi_d;
  logic        fire, push;
  logic [15:0] row;
  job_t        job;

  assign in_ready_o = !full_i;
  assign fire       = in_valid_i && in_ready_o;
  assign row        = 16'(32'(block_i) * 32'(PagesPerBlock));

  always_comb begin
    job      = '0;
    job.seq  = SeqDesel;
    job.ptr  = column_i[8];
    job.col  = column_i[7:0];
    job.addr = page_i;
    job.data = flash_byte_i;
    push     = 1'b0;
    phase_d  = phase_q;
    id_hi_d  = id_hi_q;
    unique case (op_i)
      OpReadId: begin
        job.seq = SeqReadId;
        push    = 1'b1;
        phase_d = PhId1;
      end
      OpProgStart: begin
        job.seq = SeqProg;
        push    = 1'b1;
        phase_d = PhProg;
      end
      OpWriteByte: begin
        job.seq  = SeqWrite;
        job.data = write_data_i;
        push     = (phase_q == PhProg);
      end
      OpProgCommit: begin
        job.seq = SeqCommit;
        if (phase_q == PhProg) begin
          push    = 1'b1;
          phase_d = PhPstat;
        end
      end
      OpReadStart: begin
        job.seq = SeqRdStart;
        push    = 1'b1;
        phase_d = PhRead;
      end
      OpRetByte: begin
        // meaning of a returned byte depends on the phase
        unique case (phase_q)
          PhId1: begin
            job.seq = SeqRdByte;
            push    = 1'b1;
            id_hi_d = flash_byte_i;
            phase_d = PhId2;
          end
          PhId2: begin
            job.seq = SeqIdDone;
            job.id  = {id_hi_q, flash_byte_i};
            push    = 1'b1;
            phase_d = PhIdle;
          end
          PhRead: begin
            job.seq = SeqRdByte;
            push    = 1'b1;
          end
          PhPstat, PhEstat: begin
            job.seq = SeqStatus;
            push    = 1'b1;
            phase_d = PhIdle;
          end
          default: begin
            push = 1'b0;
          end
        endcase
      end
      OpErase: begin
        job.seq  = SeqErase;
        job.addr = row;
        push     = 1'b1;
        phase_d  = PhEstat;
      end
      OpFinish: begin
        job.seq = SeqDesel;
        push    = 1'b1;
        phase_d = PhIdle;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      id_hi_q <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      id_hi_q <= id_hi_d;
    end
  end

  assign push_o = fire && push;
  assign job_o  = job;

endmodule

// ===== rtl/nfcs_queue.sv =====
// small job queue between front and back
// depends on nfcs_pkg
module nfcs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  nfcs_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output nfcs_pkg::job_t head_o
);
  import nfcs_pkg::*;

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;

  assign full_o       = (count_q == QueueCntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/nfcs_back.sv =====
// bus cycle sequencer: steps through the queued job and fills the output register
// depends on nfcs_pkg
module nfcs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  nfcs_pkg::job_t    head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output nfcs_pkg::result_t out_o
);
  import nfcs_pkg::*;

  logic [2:0] step_q;
  logic       out_valid_q;
  result_t    out_q, res;
  logic       load, emit;
  logic [7:0] ptr_cmd;

  assign ptr_cmd = head_i.ptr ? CmdPtrB : CmdPtrA;

  always_comb begin
    res      = '0;
    res.kind = KindDesel;
    unique case (head_i.seq)
      SeqReadId: begin
        unique case (step_q)
          3'd0: begin
            res.kind = KindCmd;  res.bus_byte = CmdReadId;
          end
          default: begin
            res.kind = KindAddr; res.bus_byte = IdAddr; res.last = 1'b1;
          end
        endcase
      end
      SeqProg: begin
        unique case (step_q)
          3'd0: begin
            res.kind = KindCmd;  res.bus_byte = ptr_cmd;
          end
          3'd1: begin
            res.kind = KindCmd;  res.bus_byte = CmdProgSetup;
          end
          3'd2: begin
            res.kind = KindAddr; res.bus_byte = head_i.col;
          end
          3'd3: begin
            res.kind = KindAddr; res.bus_byte = head_i.addr[7:0];
          end
          3'd4: begin
            res.kind = KindAddr; res.bus_byte = head_i.addr[15:8];
          end
          default: begin
            res.kind = KindWait; res.last = 1'b1;
          end
        endcase
      end
      SeqWrite: begin
        res.kind = KindWrite; res.bus_byte = head_i.data; res.last = 1'b1;
      end
      SeqCommit: begin
        unique case (step_q)
          3'd0: begin
            res.kind = KindCmd;  res.bus_byte = CmdProgConfirm;
          end
          3'd1: begin
            res.kind = KindWait;
          end
          default: begin
            res.kind = KindCmd;  res.bus_byte = CmdStatus; res.last = 1'b1;
          end
        endcase
      end
      SeqRdStart: begin
        unique case (step_q)
          3'd0: begin
            res.kind = KindCmd;  res.bus_byte = ptr_cmd;
          end
          3'd1: begin
            res.kind = KindAddr; res.bus_byte = head_i.col;
          end
          3'd2: begin
            res.kind = KindAddr; res.bus_byte = head_i.addr[7:0];
          end
          3'd3: begin
            res.kind = KindAddr; res.bus_byte = head_i.addr[15:8];
          end
          default: begin
            res.kind = KindWait; res.last = 1'b1;
          end
        endcase
      end
      SeqRdByte: begin
        res.kind = KindRead; res.bus_byte = head_i.data; res.last = 1'b1;
      end
      SeqIdDone: begin
        res.id_value = head_i.id;
        res.id_valid = 1'b1;
        if (step_q == 3'd0) begin
          res.kind = KindRead; res.bus_byte = head_i.data;
        end else begin
          res.kind = KindDesel; res.last = 1'b1;
        end
      end
      SeqStatus: begin
        res.status_valid = 1'b1;
        res.status_fail  = head_i.data[0];
        if (step_q == 3'd0) begin
          res.kind = KindRead; res.bus_byte = head_i.data;
        end else begin
          res.kind = KindDesel; res.last = 1'b1;
        end
      end
      SeqErase: begin
        unique case (step_q)
          3'd0: begin
            res.kind = KindCmd;  res.bus_byte = CmdEraseSetup;
          end
          3'd1: begin
            res.kind = KindAddr; res.bus_byte = head_i.addr[7:0];
          end
          3'd2: begin
            res.kind = KindAddr; res.bus_byte = head_i.addr[15:8];
          end
          3'd3: begin
            res.kind = KindCmd;  res.bus_byte = CmdEraseConfirm;
          end
          3'd4: begin
            res.kind = KindWait;
          end
          default: begin
            res.kind = KindCmd;  res.bus_byte = CmdStatus; res.last = 1'b1;
          end
        endcase
      end
      default: begin
        res.kind = KindDesel; res.last = 1'b1;
      end
    endcase
  end

  // output register takes a new word when empty or being drained
  assign load  = !out_valid_q || out_ready_i;
  assign emit  = load && head_valid_i;
  assign pop_o = emit && res.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= head_valid_i;
      end
      if (emit) begin
        step_q <= res.last ? '0 : step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/nand_flash_command_sequencer_unit.sv =====
// nand command sequencer top level: front end, job queue, bus cycle sequencer
// depends on nfcs_pkg, nfcs_front, nfcs_queue, nfcs_back and the assertion header
//
// Usage: requests enter on the in channel (valid/ready, one word per request);
// each request turns into zero to six bus cycle words on the out channel
// (valid/ready), the final one of a request flagged by last_o. Returned bytes
// sampled from the chip come back in as requests with op 5.
// Path: with the queue and output register empty, an accepted request is written
// into the job queue, and its first bus cycle word then into the output register.
// Throughput: one output word per cycle while the receiver keeps out_ready_i high,
// set by the sequencer stepping one bus cycle per clock; a data byte request
// gives one word, a command request as many words as it has bus cycles. The front
// takes a new request every cycle while the four-entry job queue has room.
// Reset: phase goes idle, the ID high byte clears, the queue and output
// register empty. No clearing pass is needed.
// Stall: when the receiver holds out_ready_i low, the output word holds, the
// sequencer waits and the queue fills; in_ready_o drops once it is full.
module nand_flash_command_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [8:0]  column_i,
  input  logic [15:0] page_i,
  input  logic [10:0] block_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  flash_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  cycle_kind_o,
  output logic [7:0]  bus_byte_o,
  output logic [15:0] id_value_o,
  output logic        id_valid_o,
  output logic        status_valid_o,
  output logic        status_fail_o,
  output logic        last_o
);
  import nfcs_pkg::*;

  `include "nand_flash_command_sequencer_unit_assert.svh"

  logic    push, full, pop, head_valid;
  job_t    push_job, head;
  result_t out_word;

  nfcs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .column_i     (column_i),
    .page_i       (page_i),
    .block_i      (block_i),
    .write_data_i (write_data_i),
    .flash_byte_i (flash_byte_i),
    .full_i       (full),
    .push_o       (push),
    .job_o        (push_job)
  );

  nfcs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  nfcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (out_word)
  );

  assign cycle_kind_o   = out_word.kind;
  assign bus_byte_o     = out_word.bus_byte;
  assign id_value_o     = out_word.id_value;
  assign id_valid_o     = out_word.id_valid;
  assign status_valid_o = out_word.status_valid;
  assign status_fail_o  = out_word.status_fail;
  assign last_o         = out_word.last;

  `NFCS_ASSERT_SAME(a_id_status_excl, out_valid_o, !(id_valid_o && status_valid_o), "id and status both flagged")
  `NFCS_ASSERT_SAME(a_flag_kind, out_valid_o && (id_valid_o || status_valid_o), (cycle_kind_o == KindRead) || (cycle_kind_o == KindDesel), "result flag on wrong cycle kind")
  `NFCS_ASSERT_SAME(a_idle_byte_zero, out_valid_o && ((cycle_kind_o == KindWait) || (cycle_kind_o == KindDesel)), bus_byte_o == 8'h00, "nonzero byte on wait or deselect")
  `NFCS_ASSERT_NEXT(a_full_blocks, full && !pop, !in_ready_o, "queue accepts while full")

endmodule

// ===== test/nand_flash_command_sequencer_unit_tb.sv =====
// testbench for the nand command sequencer: request words in, bus cycle words out
// depends on nfcs_pkg and nand_flash_command_sequencer_unit; predicts every bus cycle
// word from its own copy of the phase and id state and checks them in order
module nand_flash_command_sequencer_unit_tb;
  import nfcs_pkg::*;

  localparam int unsigned TargetRequests = 300;
  localparam int unsigned WatchdogLimit  = 1000;
  localparam int unsigned HoldStart      = 150;
  localparam int unsigned HoldLen        = 80;
  localparam int unsigned CalmStart      = 400;
  localparam int unsigned CalmEnd        = 650;
  localparam int unsigned DrainCycles    = 16;

  typedef enum logic [2:0] {
    PhIdle, PhId1, PhId2, PhProg, PhProgStat, PhRead, PhEraseStat
  } seq_phase_e;

  class bus_cycle_tracker;
    seq_phase_e  phase_q;
    logic [7:0]  id_hi_q;
    result_t     pending_cycles[$];
    result_t     burst[$];
    int unsigned errors;
    int unsigned requests;
    int unsigned ignored;
    int unsigned words_checked;

    function new();
      phase_q = PhIdle;
      id_hi_q = '0;
      errors = 0;
      requests = 0;
      ignored = 0;
      words_checked = 0;
    endfunction

    function void push_cycle(logic [2:0] kind, logic [7:0] b);
      result_t w;
      w = '0;
      w.kind = kind;
      w.bus_byte = b;
      burst.push_back(w);
    endfunction

    // works out the bus cycles caused by one accepted request
    function void note_request(logic [2:0] op, logic [8:0] column, logic [15:0] page,
                               logic [10:0] block, logic [7:0] wdata, logic [7:0] fbyte);
      logic [15:0] row;
      logic [15:0] id_word;
      logic [7:0]  ptr_cmd;
      bit          id_done;
      bit          stat_done;
      id_done = 0;
      stat_done = 0;
      id_word = '0;
      ptr_cmd = column[8] ? CmdPtrB : CmdPtrA;
      row = 16'(block * PagesPerBlock);
      burst.delete();
      case (op)
        OpReadId: begin
          push_cycle(KindCmd, CmdReadId);
          push_cycle(KindAddr, IdAddr);
          phase_q = PhId1;
        end
        OpProgStart: begin
          push_cycle(KindCmd, ptr_cmd);
          push_cycle(KindCmd, CmdProgSetup);
          push_cycle(KindAddr, column[7:0]);
          push_cycle(KindAddr, page[7:0]);
          push_cycle(KindAddr, page[15:8]);
          push_cycle(KindWait, 8'h00);
          phase_q = PhProg;
        end
        OpWriteByte: begin
          if (phase_q == PhProg) push_cycle(KindWrite, wdata);
        end
        OpProgCommit: begin
          if (phase_q == PhProg) begin
            push_cycle(KindCmd, CmdProgConfirm);
            push_cycle(KindWait, 8'h00);
            push_cycle(KindCmd, CmdStatus);
            phase_q = PhProgStat;
          end
        end
        OpReadStart: begin
          push_cycle(KindCmd, ptr_cmd);
          push_cycle(KindAddr, column[7:0]);
          push_cycle(KindAddr, page[7:0]);
          push_cycle(KindAddr, page[15:8]);
          push_cycle(KindWait, 8'h00);
          phase_q = PhRead;
        end
        OpRetByte: begin
          case (phase_q)
            PhId1: begin
              id_hi_q = fbyte;
              push_cycle(KindRead, fbyte);
              phase_q = PhId2;
            end
            PhId2: begin
              push_cycle(KindRead, fbyte);
              push_cycle(KindDesel, 8'h00);
              id_done = 1;
              id_word = {id_hi_q, fbyte};
              phase_q = PhIdle;
            end
            PhRead: push_cycle(KindRead, fbyte);
            PhProgStat, PhEraseStat: begin
              push_cycle(KindRead, fbyte);
              push_cycle(KindDesel, 8'h00);
              stat_done = 1;
              phase_q = PhIdle;
            end
            default: ;
          endcase
        end
        OpErase: begin
          // row is the block number times PagesPerBlock and fits in 16 bits
          push_cycle(KindCmd, CmdEraseSetup);
          push_cycle(KindAddr, row[7:0]);
          push_cycle(KindAddr, row[15:8]);
          push_cycle(KindCmd, CmdEraseConfirm);
          push_cycle(KindWait, 8'h00);
          push_cycle(KindCmd, CmdStatus);
          phase_q = PhEraseStat;
        end
        default: begin
          push_cycle(KindDesel, 8'h00);
          phase_q = PhIdle;
        end
      endcase
      foreach (burst[k]) begin
        if (id_done) begin
          burst[k].id_value = id_word;
          burst[k].id_valid = 1'b1;
        end
        if (stat_done) begin
          burst[k].status_valid = 1'b1;
          burst[k].status_fail = fbyte[0];
        end
        burst[k].last = (k == burst.size() - 1);
        pending_cycles.push_back(burst[k]);
      end
      requests++;
      if (burst.size() == 0) ignored++;
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_cycle(result_t got);
      result_t want;
      if (pending_cycles.size() == 0) begin
        errors++;
        $display("%0t: unexpected bus cycle word, expected none, got kind %0d byte %h",
                 $time, got.kind, got.bus_byte);
        return;
      end
      want = pending_cycles.pop_front();
      words_checked++;
      compare_field("cycle_kind", 16'(want.kind), 16'(got.kind));
      compare_field("bus_byte", 16'(want.bus_byte), 16'(got.bus_byte));
      compare_field("id_value", want.id_value, got.id_value);
      compare_field("id_valid", 16'(want.id_valid), 16'(got.id_valid));
      compare_field("status_valid", 16'(want.status_valid), 16'(got.status_valid));
      compare_field("status_fail", 16'(want.status_fail), 16'(got.status_fail));
      compare_field("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  op_i;
  logic [8:0]  column_i;
  logic [15:0] page_i;
  logic [10:0] block_i;
  logic [7:0]  write_data_i;
  logic [7:0]  flash_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  cycle_kind_o;
  logic [7:0]  bus_byte_o;
  logic [15:0] id_value_o;
  logic        id_valid_o;
  logic        status_valid_o;
  logic        status_fail_o;
  logic        last_o;

  bus_cycle_tracker tracker;

  nand_flash_command_sequencer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .column_i      (column_i),
    .page_i        (page_i),
    .block_i       (block_i),
    .write_data_i  (write_data_i),
    .flash_byte_i  (flash_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cycle_kind_o  (cycle_kind_o),
    .bus_byte_o    (bus_byte_o),
    .id_value_o    (id_value_o),
    .id_valid_o    (id_valid_o),
    .status_valid_o(status_valid_o),
    .status_fail_o (status_fail_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // one request word; valid stays high across back-to-back words unless a random gap drops it
  task automatic send_word(logic [2:0] op, logic [8:0] column, logic [15:0] page,
                           logic [10:0] block, logic [7:0] wdata, logic [7:0] fbyte);
    bit calm;
    calm = (tracker.requests >= 120 && tracker.requests < 180);
    @(negedge clk_i);
    if (!calm && $urandom_range(99) < 26) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
    op_i = op;
    column_i = column;
    page_i = page;
    block_i = block;
    write_data_i = wdata;
    flash_byte_i = fbyte;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_request(op, column, page, block, wdata, fbyte);
  endtask

  task automatic send_rand(logic [2:0] op);
    send_word(op, 9'($urandom_range(511)), 16'($urandom_range(65535)),
              11'($urandom_range(2047)), 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic send_byte(logic [2:0] op, logic [7:0] b);
    send_word(op, 9'($urandom_range(511)), 16'($urandom_range(65535)),
              11'($urandom_range(2047)), b, b);
  endtask

  task automatic run_read_id();
    send_rand(OpReadId);
    send_rand(OpRetByte);
    // broken variant leaves the id half read
    if ($urandom_range(99) >= 15) send_rand(OpRetByte);
  endtask

  task automatic run_program();
    int unsigned nbytes;
    nbytes = $urandom_range(8, 1);
    send_rand(OpProgStart);
    repeat (nbytes) send_rand(OpWriteByte);
    if ($urandom_range(99) >= 15) begin
      send_rand(OpProgCommit);
      send_rand(OpRetByte);
    end
  endtask

  task automatic run_page_read();
    int unsigned nbytes;
    nbytes = $urandom_range(8, 1);
    send_rand(OpReadStart);
    repeat (nbytes) send_rand(OpRetByte);
    if ($urandom_range(99) >= 15) send_rand(OpFinish);
  endtask

  task automatic run_erase();
    send_rand(OpErase);
    if ($urandom_range(99) >= 15) send_rand(OpRetByte);
  endtask

  // receiver: random stalls, one long hold-off, one stretch always ready
  initial begin
    int unsigned cyc;
    cyc = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc >= HoldStart && cyc < HoldStart + HoldLen) out_ready_i = 1'b0;
      else if (cyc >= CalmStart && cyc < CalmEnd) out_ready_i = 1'b1;
      else out_ready_i = ($urandom_range(99) >= 26);
    end
  end

  initial begin
    result_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.kind = cycle_kind_o;
        got.bus_byte = bus_byte_o;
        got.id_value = id_value_o;
        got.id_valid = id_valid_o;
        got.status_valid = status_valid_o;
        got.status_fail = status_fail_o;
        got.last = last_o;
        tracker.check_cycle(got);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no word moved for %0d cycles", WatchdogLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned pick;
    tracker = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = OpFinish;
    column_i = '0;
    page_i = '0;
    block_i = '0;
    write_data_i = '0;
    flash_byte_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // requests that must be ignored, then finish in idle
    send_byte(OpRetByte, 8'hFF);
    send_byte(OpWriteByte, 8'hFF);
    send_rand(OpProgCommit);
    send_rand(OpFinish);
    // id from extreme bytes
    send_rand(OpReadId);
    send_byte(OpRetByte, 8'hFF);
    send_byte(OpRetByte, 8'h00);
    // program at the top column and page, returned byte ignored while programming
    send_word(OpProgStart, 9'h1FF, 16'hFFFF, 11'h0, 8'h00, 8'h00);
    send_byte(OpRetByte, 8'h5A);
    send_byte(OpWriteByte, 8'h00);
    send_byte(OpWriteByte, 8'hFF);
    send_rand(OpProgCommit);
    send_byte(OpRetByte, 8'h01);
    // page read from the bottom
    send_word(OpReadStart, 9'h000, 16'h0000, 11'h7FF, 8'hFF, 8'hFF);
    send_byte(OpRetByte, 8'h00);
    send_byte(OpRetByte, 8'hFF);
    send_rand(OpFinish);
    // erase at the top block, then at block zero
    send_word(OpErase, 9'h1FF, 16'hFFFF, 11'h7FF, 8'hFF, 8'hFF);
    send_byte(OpRetByte, 8'hFE);
    send_word(OpErase, 9'h000, 16'h0000, 11'h000, 8'h00, 8'h00);
    // program dropped by a new request while busy
    send_word(OpProgStart, 9'h100, 16'h1234, 11'h3FF, 8'h00, 8'h00);
    send_rand(OpReadId);
    send_byte(OpRetByte, 8'hA5);
    send_word(OpProgStart, 9'h0FF, 16'h00FF, 11'h400, 8'h00, 8'h00);
    send_rand(OpProgCommit);
    send_byte(OpRetByte, 8'h00);

    while (tracker.requests - tracker.ignored < TargetRequests) begin
      pick = $urandom_range(99);
      if (pick < 20) run_read_id();
      else if (pick < 45) run_program();
      else if (pick < 70) run_page_read();
      else if (pick < 85) run_erase();
      else send_rand(3'($urandom_range(7)));
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;

    while (tracker.pending_cycles.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d requests (%0d ignored) and %0d bus cycle words",
             tracker.requests, tracker.ignored, tracker.words_checked);
    $display("ops: read id, program, page read, erase, finish, with stalls and a long hold-off");
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
